// ===== rtl/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// arc_pkg
// Types, codes and constants shared by the ARP resolution cache.
// ----------------------------------------------------------------------------
package arc_pkg;

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_RECV = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [1:0] KIND_IPV4 = 2'd0;
	localparam logic [1:0] KIND_ARP  = 2'd1;
	localparam logic [1:0] KIND_UP   = 2'd2;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_REQ   = 2'd1;
	localparam logic [1:0] OP_REPLY = 2'd2;

	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_ARP  = 16'h0806;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] REG_LOCAL_MAC = 2'd0;
	localparam logic [1:0] REG_LOCAL_IP  = 2'd1;
	localparam logic [1:0] REG_LIFETIME  = 2'd2;
	localparam logic [1:0] REG_HOLD      = 2'd3;

	localparam logic [31:0] LIFETIME_RST = 32'd30000;
	localparam logic [31:0] HOLD_RST     = 32'd5000;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] hop_ip;
		logic [15:0] dgram_tag;
		logic [47:0] frame_dst_mac;
		logic [15:0] frame_ethertype;
		logic [15:0] arp_op;
		logic [31:0] arp_sender_ip;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_target_ip;
		logic [31:0] elapsed_ms;
	} in_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [47:0] dest_mac;
		logic [15:0] ether_type;
		logic [1:0]  out_arp_op;
		logic [47:0] out_target_mac;
		logic [31:0] out_target_ip;
		logic [15:0] out_tag;
		logic        last;
	} out_t;

	// controls broadcast to one row of entry cells
	typedef struct packed {
		logic        wr;
		logic        age;
		logic [31:0] look;
		logic [31:0] key;
		logic [31:0] life;
		logic [31:0] elapsed;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_EVICT,
		S_FLUSH
	} state_t;

endpackage

// ===== rtl/arc_if.sv =====
// ----------------------------------------------------------------------------
// arc_if
// Handshake channels of the ARP resolution cache.
// ----------------------------------------------------------------------------
interface arc_in_if;
	logic         valid;
	logic         ready;
	arc_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface arc_out_if;
	logic          valid;
	logic          ready;
	arc_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface arc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/arc_cell.sv =====
// ----------------------------------------------------------------------------
// arc_cell
// One table entry: key, data, time left and valid; matches and ages locally.
// ----------------------------------------------------------------------------
module arc_cell #(
	parameter int DATA_W = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  arc_pkg::cell_ctl_t  ctl,
	input  logic                sel,
	input  logic [DATA_W-1:0]   wr_data,
	output logic                valid,
	output logic [31:0]         key,
	output logic [DATA_W-1:0]   data,
	output logic [31:0]         left,
	output logic                hit
);
	logic        valid_q;
	logic [31:0] key_q;
	logic [DATA_W-1:0] data_q;
	logic [31:0] left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr && sel) begin
			valid_q <= 1'b1;
		end else if (ctl.age && valid_q && left_q <= ctl.elapsed) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && sel) begin
			key_q  <= ctl.key;
			data_q <= wr_data;
			left_q <= ctl.life;
		end else if (ctl.age && valid_q && left_q > ctl.elapsed) begin
			left_q <= left_q - ctl.elapsed;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign data  = data_q;
	assign left  = left_q;
	assign hit   = valid_q && (key_q == ctl.look);

endmodule

// ===== rtl/arp_resolution_cache.sv =====
// ----------------------------------------------------------------------------
// arp_resolution_cache
// ARP engine: neighbor cache, request hold table and parked datagram store.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A tick or a plain receive ends in the
// dispatch step; a send or learn that must replace an entry of a full table
// adds a scan over every entry (CACHE_ENTRIES or WAIT_ENTRIES) and an evict
// step; an ARP receive then walks the park store, one slot a cycle while the
// result side does not stall. Cache and hold entries are rows of cells that
// compare and age in parallel; the park store stays packed in arrival order
// and a fill count marks its valid slots. Results leave through one output
// register; config writes are always ready.
// ----------------------------------------------------------------------------
module arp_resolution_cache #(
	parameter int CACHE_ENTRIES = 16,
	parameter int WAIT_ENTRIES  = 16,
	parameter int PARK_SLOTS    = 16,
	parameter int TAG_BITS      = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	arc_in_if.sink    req,
	arc_out_if.source rsp,
	arc_cfg_if.sink   cfg
);
	localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int WIW  = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
	localparam int PIW  = (PARK_SLOTS > 1) ? $clog2(PARK_SLOTS) : 1;
	localparam int PCW  = $clog2(PARK_SLOTS + 1);
	localparam int MAXN = (CACHE_ENTRIES > WAIT_ENTRIES) ? CACHE_ENTRIES : WAIT_ENTRIES;
	localparam int SCW  = $clog2(MAXN) + 1;
	localparam int TB   = (TAG_BITS < 16) ? TAG_BITS : 16;
	localparam logic [15:0] TAG_MASK = 16'((17'd1 << TB) - 17'd1);

	// config registers
	logic [47:0] local_mac_q;
	logic [31:0] local_ip_q, lifetime_q, hold_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q <= '0;
			local_ip_q  <= '0;
			lifetime_q  <= arc_pkg::LIFETIME_RST;
			hold_q      <= arc_pkg::HOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				arc_pkg::REG_LOCAL_MAC: local_mac_q <= cfg.wdata;
				arc_pkg::REG_LOCAL_IP:  local_ip_q  <= cfg.wdata[31:0];
				arc_pkg::REG_LIFETIME:  lifetime_q  <= cfg.wdata[31:0];
				arc_pkg::REG_HOLD:      hold_q      <= cfg.wdata[31:0];
				default: ;
			endcase
		end
	end

	// latched input beat
	arc_pkg::in_t in_q;
	arc_pkg::state_t st_q, st_nx;

	assign req.ready = (st_q == arc_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) in_q <= req.data;
	end

	// cache and hold rows
	arc_pkg::cell_ctl_t cctl, wctl;
	logic [CACHE_ENTRIES-1:0] c_sel, c_valid, c_hit;
	logic [31:0] c_left [CACHE_ENTRIES];
	logic [47:0] c_mac  [CACHE_ENTRIES];
	logic [WAIT_ENTRIES-1:0] w_sel, w_valid, w_hit;
	logic [31:0] w_left [WAIT_ENTRIES];

	for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cache
		arc_cell #(.DATA_W(48)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(cctl), .sel(c_sel[g]),
			.wr_data(in_q.arp_sender_mac), .valid(c_valid[g]), .key(),
			.data(c_mac[g]), .left(c_left[g]), .hit(c_hit[g])
		);
	end

	for (genvar g = 0; g < WAIT_ENTRIES; g++) begin : g_wait
		arc_cell #(.DATA_W(1)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(wctl), .sel(w_sel[g]),
			.wr_data(1'b0), .valid(w_valid[g]), .key(), .data(),
			.left(w_left[g]), .hit(w_hit[g])
		);
	end

	// priority encodes: first match, first free
	logic [CIW-1:0] c_hit_idx, c_free_idx;
	logic [WIW-1:0] w_free_idx;
	always_comb begin
		c_hit_idx  = '0;
		c_free_idx = '0;
		w_free_idx = '0;
		for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
			if (c_hit[k])   c_hit_idx  = CIW'(k);
			if (!c_valid[k]) c_free_idx = CIW'(k);
		end
		for (int k = WAIT_ENTRIES - 1; k >= 0; k--) begin
			if (!w_valid[k]) w_free_idx = WIW'(k);
		end
	end

	logic c_hit_any, c_free_any, w_held, w_free_any;
	assign c_hit_any  = |c_hit;
	assign c_free_any = ~&c_valid;
	assign w_held     = |w_hit;
	assign w_free_any = ~&w_valid;

	// park store, packed from slot 0
	logic [31:0]   park_ip  [PARK_SLOTS];
	logic [TB-1:0] park_tag [PARK_SLOTS];
	logic [PCW-1:0] park_cnt_q, fi_q, fj_q;
	logic [PARK_SLOTS-1:0] pm, pm_q;

	always_comb begin
		for (int k = 0; k < PARK_SLOTS; k++) begin
			pm[k] = (PCW'(k) < park_cnt_q) && (park_ip[k] == in_q.arp_sender_ip);
		end
	end

	// beat decode
	logic is_send, is_recv, is_tick, drop, is_ipv4, is_arp, reply;
	assign is_send = (in_q.action == arc_pkg::ACT_SEND);
	assign is_recv = (in_q.action == arc_pkg::ACT_RECV);
	assign is_tick = (in_q.action == arc_pkg::ACT_TICK);
	assign drop    = (in_q.frame_dst_mac != arc_pkg::MAC_BCAST) &&
	                 (in_q.frame_dst_mac != local_mac_q);
	assign is_ipv4 = is_recv && !drop && (in_q.frame_ethertype == arc_pkg::ET_IPV4);
	assign is_arp  = is_recv && !drop && (in_q.frame_ethertype == arc_pkg::ET_ARP);
	assign reply   = is_arp && (in_q.arp_op == arc_pkg::ARP_OP_REQUEST) &&
	                 (in_q.arp_target_ip == local_ip_q);

	// output register
	logic ov_q, can_emit;
	arc_pkg::out_t ob_q, emit_d;
	logic emit;
	assign can_emit = !ov_q || rsp.ready;
	assign rsp.valid = ov_q;
	assign rsp.data  = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) ob_q <= emit_d;
	end

	// replacement scan over a full table (least time left, lowest index)
	logic tgt_wait_q;
	logic [SCW-1:0] sc_q;
	logic [31:0] best_val_q, cur_left;
	logic [SCW-1:0] best_idx_q;
	logic scan_done;
	assign cur_left  = tgt_wait_q ? w_left[sc_q[WIW-1:0]] : c_left[sc_q[CIW-1:0]];
	assign scan_done = tgt_wait_q ? (sc_q == SCW'(WAIT_ENTRIES))
	                              : (sc_q == SCW'(CACHE_ENTRIES));

	always_ff @(posedge clk) begin
		if (st_q == arc_pkg::S_DISPATCH) begin
			tgt_wait_q <= is_send;
			sc_q       <= SCW'(1);
			best_idx_q <= '0;
			best_val_q <= is_send ? w_left[0] : c_left[0];
		end else if (st_q == arc_pkg::S_SCAN && !scan_done) begin
			sc_q <= sc_q + SCW'(1);
			if (cur_left < best_val_q) begin
				best_val_q <= cur_left;
				best_idx_q <= sc_q;
			end
		end
	end

	// datagram needing a result this cycle in dispatch
	logic need_emit, go;
	assign need_emit = (is_send && (c_hit_any || !w_held)) || is_ipv4 || reply;
	assign go = !need_emit || can_emit;

	// flush walk
	logic flush_busy, flush_hit, flush_last;
	assign flush_busy = (fi_q != park_cnt_q);
	assign flush_hit  = pm_q[fi_q[PIW-1:0]];
	always_comb begin
		flush_last = 1'b1;
		for (int k = 0; k < PARK_SLOTS; k++) begin
			if (pm_q[k] && PCW'(k) > fi_q) flush_last = 1'b0;
		end
	end

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			arc_pkg::S_IDLE: begin
				if (req.valid) st_nx = arc_pkg::S_DISPATCH;
			end
			arc_pkg::S_DISPATCH: begin
				if (go) begin
					st_nx = arc_pkg::S_IDLE;
					if (is_send && !c_hit_any && !w_held && !w_free_any)
						st_nx = arc_pkg::S_SCAN;
					if (is_arp)
						st_nx = (c_hit_any || c_free_any) ? arc_pkg::S_FLUSH
						                                  : arc_pkg::S_SCAN;
				end
			end
			arc_pkg::S_SCAN: begin
				if (scan_done) st_nx = arc_pkg::S_EVICT;
			end
			arc_pkg::S_EVICT: begin
				st_nx = tgt_wait_q ? arc_pkg::S_IDLE : arc_pkg::S_FLUSH;
			end
			arc_pkg::S_FLUSH: begin
				if (!flush_busy) st_nx = arc_pkg::S_IDLE;
			end
			default: st_nx = arc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= arc_pkg::S_IDLE;
		else         st_q <= st_nx;
	end

	// outputs of the sequencer
	logic park_push, flush_move, flush_adv, flush_init;
	always_comb begin
		emit       = 1'b0;
		emit_d     = '0;
		park_push  = 1'b0;
		flush_move = 1'b0;
		flush_adv  = 1'b0;
		flush_init = 1'b0;
		cctl         = '0;
		cctl.look    = is_send ? in_q.hop_ip : in_q.arp_sender_ip;
		cctl.key     = in_q.arp_sender_ip;
		cctl.life    = lifetime_q;
		cctl.elapsed = in_q.elapsed_ms;
		wctl         = '0;
		wctl.look    = in_q.hop_ip;
		wctl.key     = in_q.hop_ip;
		wctl.life    = hold_q;
		wctl.elapsed = in_q.elapsed_ms;
		c_sel = '0;
		w_sel = '0;
		case (st_q)
			arc_pkg::S_DISPATCH: begin
				if (go) begin
					flush_init = 1'b1;
					if (is_send && c_hit_any) begin
						emit = 1'b1;
						emit_d.out_kind   = arc_pkg::KIND_IPV4;
						emit_d.dest_mac   = c_mac[c_hit_idx];
						emit_d.ether_type = arc_pkg::ET_IPV4;
						emit_d.out_tag    = in_q.dgram_tag & TAG_MASK;
						emit_d.last       = 1'b1;
					end else if (is_send) begin
						park_push = (park_cnt_q < PCW'(PARK_SLOTS));
						if (!w_held) begin
							emit = 1'b1;
							emit_d.out_kind      = arc_pkg::KIND_ARP;
							emit_d.dest_mac      = arc_pkg::MAC_BCAST;
							emit_d.ether_type    = arc_pkg::ET_ARP;
							emit_d.out_arp_op    = arc_pkg::OP_REQ;
							emit_d.out_target_ip = in_q.hop_ip;
							emit_d.last          = 1'b1;
							if (w_free_any) begin
								wctl.wr = 1'b1;
								w_sel[w_free_idx] = 1'b1;
							end
						end
					end
					if (is_ipv4) begin
						emit = 1'b1;
						emit_d.out_kind = arc_pkg::KIND_UP;
						emit_d.out_tag  = in_q.dgram_tag & TAG_MASK;
						emit_d.last     = 1'b1;
					end
					if (is_arp) begin
						if (reply) begin
							emit = 1'b1;
							emit_d.out_kind       = arc_pkg::KIND_ARP;
							emit_d.dest_mac       = in_q.arp_sender_mac;
							emit_d.ether_type     = arc_pkg::ET_ARP;
							emit_d.out_arp_op     = arc_pkg::OP_REPLY;
							emit_d.out_target_mac = in_q.arp_sender_mac;
							emit_d.out_target_ip  = in_q.arp_sender_ip;
							emit_d.last           = ~|pm;
						end
						if (c_hit_any) begin
							cctl.wr = 1'b1;
							c_sel[c_hit_idx] = 1'b1;
						end else if (c_free_any) begin
							cctl.wr = 1'b1;
							c_sel[c_free_idx] = 1'b1;
						end
					end
					if (is_tick) begin
						cctl.age = 1'b1;
						wctl.age = 1'b1;
					end
				end
			end
			arc_pkg::S_EVICT: begin
				if (tgt_wait_q) begin
					wctl.wr = 1'b1;
					w_sel[best_idx_q[WIW-1:0]] = 1'b1;
				end else begin
					cctl.wr = 1'b1;
					c_sel[best_idx_q[CIW-1:0]] = 1'b1;
				end
			end
			arc_pkg::S_FLUSH: begin
				if (flush_busy) begin
					if (flush_hit) begin
						if (can_emit) begin
							emit = 1'b1;
							emit_d.out_kind   = arc_pkg::KIND_IPV4;
							emit_d.dest_mac   = in_q.arp_sender_mac;
							emit_d.ether_type = arc_pkg::ET_IPV4;
							emit_d.out_tag    = 16'(park_tag[fi_q[PIW-1:0]]);
							emit_d.last       = flush_last;
							flush_adv = 1'b1;
						end
					end else begin
						flush_move = 1'b1;
						flush_adv  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// park store update
	always_ff @(posedge clk) begin
		if (park_push) begin
			park_ip[park_cnt_q[PIW-1:0]]  <= in_q.hop_ip;
			park_tag[park_cnt_q[PIW-1:0]] <= in_q.dgram_tag[TB-1:0];
		end else if (flush_move) begin
			park_ip[fj_q[PIW-1:0]]  <= park_ip[fi_q[PIW-1:0]];
			park_tag[fj_q[PIW-1:0]] <= park_tag[fi_q[PIW-1:0]];
		end
		if (flush_init) pm_q <= pm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			park_cnt_q <= '0;
			fi_q <= '0;
			fj_q <= '0;
		end else begin
			if (park_push) park_cnt_q <= park_cnt_q + PCW'(1);
			if (flush_init) begin
				fi_q <= '0;
				fj_q <= '0;
			end else begin
				if (flush_adv)  fi_q <= fi_q + PCW'(1);
				if (flush_move) fj_q <= fj_q + PCW'(1);
			end
			if (st_q == arc_pkg::S_FLUSH && !flush_busy) park_cnt_q <= fj_q;
		end
	end

	// checks
	a_park_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		park_cnt_q <= PCW'(PARK_SLOTS))
		else $error("park count overflow");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == arc_pkg::S_FLUSH |-> fj_q <= fi_q)
		else $error("compaction write passed read");

	a_tick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == arc_pkg::S_DISPATCH && is_tick) |=> st_q == arc_pkg::S_IDLE)
		else $error("tick did not finish in one cycle");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (st_q == arc_pkg::S_DISPATCH || st_q == arc_pkg::S_FLUSH))
		else $error("result loaded outside dispatch or flush");

endmodule
